[hw/rtl/ped_pkg.sv]
// Shared types and constants of the point to ellipsoid distance block.
package ped_pkg;

  localparam int unsigned AXIS_W  = 31;
  localparam int unsigned COORD_W = 32;

  localparam logic [1:0] REG_AXIS_MAJOR  = 2'd0;
  localparam logic [1:0] REG_AXIS_MIDDLE = 2'd1;
  localparam logic [1:0] REG_AXIS_MINOR  = 2'd2;

  // Largest magnitude a nearest-point coordinate may take.
  localparam logic [63:0] MAG_MAX = 64'h0000_0000_7FFF_FFFF;

  localparam logic [6:0] MUL_STEPS  = 7'd4;
  localparam logic [6:0] WORD_STEPS = 7'd64;

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } alu_op_e;

  // MUL: a * b.  DIV: x / b, saturated.  SQRT: floor root of x.
  typedef struct packed {
    alu_op_e      op;
    logic [63:0]  a;
    logic [63:0]  b;
    logic [127:0] x;
  } alu_req_t;

endpackage

[hw/rtl/point_ellipsoid_distance.sv]
// Top level: closest point on an axis-aligned ellipsoid and distance to it.
// A query is taken when start is high and busy is low; busy then stays high
// until the result appears, marked for one cycle by done_o, which cannot be
// held off. All arithmetic runs on one shared unit, which works through a
// divide or square root one bit a cycle.
// Configuration writes are taken at any edge with cfg_we_i and must only be
// issued while busy is low.
module point_ellipsoid_distance import ped_pkg::*; #(
  parameter int unsigned BISECT_STEPS = 10,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_idx_i,
  input  logic [AXIS_W-1:0]         cfg_wdata_i,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] query_x_i,
  input  logic signed [COORD_W-1:0] query_y_i,
  input  logic signed [COORD_W-1:0] query_z_i,
  output logic                      done_o,
  output logic [COORD_W-1:0]        dist_res_o,
  output logic signed [COORD_W-1:0] near_x_o,
  output logic signed [COORD_W-1:0] near_y_o,
  output logic signed [COORD_W-1:0] near_z_o
);

  localparam int unsigned RB     = 2 * FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(BISECT_STEPS + 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(BISECT_STEPS);
  localparam logic [AXIS_W-1:0] AXIS_ONE  = AXIS_W'(1) << FRAC_BITS;
  localparam logic [127:0]      ONE_SQ    = 128'(1) << (2 * RB);
  localparam logic [63:0]       CAP_R     = 64'(2) << RB;

  typedef enum logic [5:0] {
    S_IDLE, S_R_INIT, S_R_Q, S_R_QQ, S_R_E, S_R_N, S_R_S, S_R_CMP, S_R_SQRT,
    S_B_MID, S_B_R, S_B_RR, S_B_CMP, S_R_XM, S_R_XD, S_OUT,
    S_P_E2, S_P_A0, S_P_A1, S_P_N0, S_P_N1, S_P_Q0, S_P_Q1, S_P_S0, S_P_S1,
    S_P_X0, S_P_X1, S_P_RT, S_P_X2,
    S_E_START, S_E_D0, S_E_D1, S_E_Q, S_E_QQ, S_E_RT, S_E_X0, S_E_X1,
    S_F_INIT, S_F_D, S_F_SQ
  } state_e;

  typedef enum logic [1:0] {
    M_3D,
    M_12,
    M_02,
    M_01
  } mode_e;

  logic [AXIS_W-1:0] major_q, middle_q, minor_q;

  state_e            state_q;
  mode_e             mode_q;
  logic              wait_q;
  logic [1:0]        i_q, km_q;
  logic [STEP_W-1:0] step_q;

  logic [AXIS_W-1:0]  ax_q [3];
  logic [COORD_W-1:0] pv_q [3];
  logic               neg_q [3];
  logic [63:0]        xv_q [3];

  logic [AXIS_W-1:0]  sa_q [3];
  logic [COORD_W-1:0] sp_q [3];
  logic [63:0]        se_q [3];
  logic [63:0]        sn_q [3];
  logic [63:0]        sx_q [3];
  logic [63:0]        em_q, nm_q, lo_q, hi_q, u_q, tq_q, ta_q;
  logic [63:0]        den0_q, den1_q, num0_q, num1_q, q0_q, q1_q;
  logic [127:0]       g_q, s_q;

  logic               done_q;
  logic [COORD_W-1:0] dist_q;
  logic [COORD_W-1:0] near_q [3];

  alu_req_t     alu_req;
  logic         alu_use, alu_start, alu_done;
  logic [127:0] alu_res;

  logic [AXIS_W-1:0]  am_w, amid0_w, amid_w, amin0_w, amin_w;
  logic [COORD_W-1:0] mag_w [3];
  logic               sgn_w [3];
  logic               sel12_w, sel02_w, selz_w;
  logic [63:0] sa_r, sp_r, se_r, sn_r, den_b, rq_w, mid_w, xc_w, pr_w, dabs_w;
  logic [127:0] gsum_w;

  // raise zero axes to one LSB, then force the order major >= middle >= minor
  assign am_w    = (major_q == '0) ? AXIS_W'(1) : major_q;
  assign amid0_w = (middle_q == '0) ? AXIS_W'(1) : middle_q;
  assign amid_w  = (amid0_w > am_w) ? am_w : amid0_w;
  assign amin0_w = (minor_q == '0) ? AXIS_W'(1) : minor_q;
  assign amin_w  = (amin0_w > amid_w) ? amid_w : amin0_w;

  assign sgn_w[0] = query_x_i[COORD_W-1];
  assign sgn_w[1] = query_y_i[COORD_W-1];
  assign sgn_w[2] = query_z_i[COORD_W-1];
  assign mag_w[0] = sgn_w[0] ? ~query_x_i + COORD_W'(1) : query_x_i;
  assign mag_w[1] = sgn_w[1] ? ~query_y_i + COORD_W'(1) : query_y_i;
  assign mag_w[2] = sgn_w[2] ? ~query_z_i + COORD_W'(1) : query_z_i;

  // solver slot layout for queries on one coordinate plane or the minor axis
  assign sel12_w = (mag_w[2] != '0) && (mag_w[1] != '0) && (mag_w[0] == '0);
  assign sel02_w = (mag_w[2] != '0) && (mag_w[1] == '0) && (mag_w[0] != '0);
  assign selz_w  = (mag_w[2] != '0) && (mag_w[1] == '0) && (mag_w[0] == '0);

  assign sa_r   = 64'(sa_q[i_q]);
  assign sp_r   = 64'(sp_q[i_q]);
  assign se_r   = se_q[i_q];
  assign sn_r   = sn_q[i_q];
  assign den_b  = u_q + se_r - em_q;
  assign rq_w   = (alu_res[63:0] > CAP_R) ? CAP_R : alu_res[63:0];
  assign mid_w  = lo_q + ((hi_q - lo_q) >> 1);
  assign gsum_w = g_q + alu_res;
  assign xc_w   = (xv_q[i_q] > MAG_MAX) ? MAG_MAX : xv_q[i_q];
  assign pr_w   = 64'(pv_q[i_q]);
  assign dabs_w = (xc_w > pr_w) ? xc_w - pr_w : pr_w - xc_w;

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign dist_res_o = dist_q;
  assign near_x_o   = near_q[0];
  assign near_y_o   = near_q[1];
  assign near_z_o   = near_q[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      major_q  <= AXIS_ONE;
      middle_q <= AXIS_ONE;
      minor_q  <= AXIS_ONE;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AXIS_MAJOR:  major_q  <= cfg_wdata_i;
        REG_AXIS_MIDDLE: middle_q <= cfg_wdata_i;
        REG_AXIS_MINOR:  minor_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // operand select for the shared unit
  always_comb begin
    alu_use = 1'b1;
    alu_req = '{op: OP_MUL, a: 64'd0, b: 64'd0, x: 128'd0};
    unique case (state_q)
      S_R_Q:    alu_req = '{op: OP_DIV, a: 64'd0, b: sa_r, x: 128'(sp_r) << RB};
      S_R_QQ:   alu_req = '{op: OP_MUL, a: tq_q, b: tq_q, x: 128'd0};
      S_R_E:    alu_req = '{op: OP_MUL, a: sa_r, b: sa_r, x: 128'd0};
      S_R_N:    alu_req = '{op: OP_MUL, a: sa_r, b: sp_r, x: 128'd0};
      S_R_S:    alu_req = '{op: OP_MUL, a: sn_r, b: sn_r, x: 128'd0};
      S_R_SQRT: alu_req = '{op: OP_SQRT, a: 64'd0, b: 64'd0, x: s_q};
      S_B_R:    alu_req = '{op: OP_DIV, a: 64'd0, b: den_b, x: 128'(sn_r) << RB};
      S_B_RR:   alu_req = '{op: OP_MUL, a: tq_q, b: tq_q, x: 128'd0};
      S_R_XM:   alu_req = '{op: OP_MUL, a: se_r, b: sp_r, x: 128'd0};
      S_R_XD:   alu_req = '{op: OP_DIV, a: 64'd0, b: den_b, x: s_q};
      S_P_E2:   alu_req = '{op: OP_MUL, a: 64'(ax_q[2]), b: 64'(ax_q[2]), x: 128'd0};
      S_P_A0:   alu_req = '{op: OP_MUL, a: 64'(ax_q[0]), b: 64'(ax_q[0]), x: 128'd0};
      S_P_A1:   alu_req = '{op: OP_MUL, a: 64'(ax_q[1]), b: 64'(ax_q[1]), x: 128'd0};
      S_P_N0:   alu_req = '{op: OP_MUL, a: 64'(ax_q[0]), b: 64'(pv_q[0]), x: 128'd0};
      S_P_N1:   alu_req = '{op: OP_MUL, a: 64'(ax_q[1]), b: 64'(pv_q[1]), x: 128'd0};
      S_P_Q0:   alu_req = '{op: OP_DIV, a: 64'd0, b: den0_q, x: 128'(num0_q) << RB};
      S_P_Q1:   alu_req = '{op: OP_DIV, a: 64'd0, b: den1_q, x: 128'(num1_q) << RB};
      S_P_S0:   alu_req = '{op: OP_MUL, a: q0_q, b: q0_q, x: 128'd0};
      S_P_S1:   alu_req = '{op: OP_MUL, a: q1_q, b: q1_q, x: 128'd0};
      S_P_X0:   alu_req = '{op: OP_MUL, a: 64'(ax_q[0]), b: q0_q, x: 128'd0};
      S_P_X1:   alu_req = '{op: OP_MUL, a: 64'(ax_q[1]), b: q1_q, x: 128'd0};
      S_P_RT:   alu_req = '{op: OP_SQRT, a: 64'd0, b: 64'd0, x: ONE_SQ - g_q};
      S_P_X2:   alu_req = '{op: OP_MUL, a: 64'(ax_q[2]), b: tq_q, x: 128'd0};
      S_E_D0:   alu_req = '{op: OP_MUL, a: 64'(ax_q[0]), b: 64'(ax_q[0]), x: 128'd0};
      S_E_D1:   alu_req = '{op: OP_MUL, a: 64'(ax_q[1]), b: 64'(ax_q[1]), x: 128'd0};
      S_E_Q:    alu_req = '{op: OP_DIV, a: 64'd0, b: den0_q, x: 128'(num0_q) << RB};
      S_E_QQ:   alu_req = '{op: OP_MUL, a: q0_q, b: q0_q, x: 128'd0};
      S_E_RT:   alu_req = '{op: OP_SQRT, a: 64'd0, b: 64'd0, x: ONE_SQ - g_q};
      S_E_X0:   alu_req = '{op: OP_MUL, a: 64'(ax_q[0]), b: q0_q, x: 128'd0};
      S_E_X1:   alu_req = '{op: OP_MUL, a: 64'(ax_q[1]), b: tq_q, x: 128'd0};
      S_F_D:    alu_req = '{op: OP_MUL, a: dabs_w, b: dabs_w, x: 128'd0};
      S_F_SQ:   alu_req = '{op: OP_SQRT, a: 64'd0, b: 64'd0, x: s_q};
      default:  alu_use = 1'b0;
    endcase
  end

  assign alu_start = alu_use && !wait_q;

  ped_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (alu_start),
    .req_i   (alu_req),
    .done_o  (alu_done),
    .res_o   (alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_3D;
      wait_q  <= 1'b0;
      done_q  <= 1'b0;
      i_q     <= 2'd0;
      km_q    <= 2'd0;
      step_q  <= '0;
      ax_q    <= '{default: '0};
      pv_q    <= '{default: '0};
      neg_q   <= '{default: 1'b0};
      xv_q    <= '{default: '0};
      sa_q    <= '{default: '0};
      sp_q    <= '{default: '0};
      se_q    <= '{default: '0};
      sn_q    <= '{default: '0};
      sx_q    <= '{default: '0};
      near_q  <= '{default: '0};
      em_q    <= '0;
      nm_q    <= '0;
      lo_q    <= '0;
      hi_q    <= '0;
      u_q     <= '0;
      tq_q    <= '0;
      ta_q    <= '0;
      den0_q  <= '0;
      den1_q  <= '0;
      num0_q  <= '0;
      num1_q  <= '0;
      q0_q    <= '0;
      q1_q    <= '0;
      g_q     <= '0;
      s_q     <= '0;
      dist_q  <= '0;
    end else begin
      done_q <= (state_q == S_F_SQ) && alu_done;
      if (alu_start) begin
        wait_q <= 1'b1;
      end else if (alu_done) begin
        wait_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: if (start) begin
          ax_q[0] <= am_w;
          ax_q[1] <= amid_w;
          ax_q[2] <= amin_w;
          for (int j = 0; j < 3; j++) begin
            pv_q[j]  <= mag_w[j];
            neg_q[j] <= sgn_w[j];
          end
          xv_q[0] <= '0;
          xv_q[1] <= '0;
          xv_q[2] <= selz_w ? 64'(amin_w) : 64'd0;
          sa_q[0] <= sel12_w ? amid_w : am_w;
          sa_q[1] <= (sel12_w || sel02_w) ? amin_w : amid_w;
          sa_q[2] <= amin_w;
          sp_q[0] <= sel12_w ? mag_w[1] : mag_w[0];
          sp_q[1] <= (sel12_w || sel02_w) ? mag_w[2] : mag_w[1];
          sp_q[2] <= mag_w[2];
          if (mag_w[2] != '0) begin
            if (mag_w[1] != '0) begin
              if (mag_w[0] != '0) begin
                mode_q  <= M_3D;
                km_q    <= 2'd2;
                state_q <= S_R_INIT;
              end else begin
                mode_q  <= M_12;
                km_q    <= 2'd1;
                state_q <= S_R_INIT;
              end
            end else if (mag_w[0] != '0) begin
              mode_q  <= M_02;
              km_q    <= 2'd1;
              state_q <= S_R_INIT;
            end else begin
              state_q <= S_F_INIT;
            end
          end else begin
            state_q <= S_P_E2;
          end
        end

        S_R_INIT: begin
          g_q     <= '0;
          s_q     <= '0;
          i_q     <= 2'd0;
          step_q  <= '0;
          state_q <= S_R_Q;
        end
        S_R_Q: if (alu_done) begin
          tq_q    <= rq_w;
          state_q <= S_R_QQ;
        end
        S_R_QQ: if (alu_done) begin
          g_q     <= gsum_w;
          state_q <= S_R_E;
        end
        S_R_E: if (alu_done) begin
          se_q[i_q] <= alu_res[63:0];
          if (i_q == km_q) em_q <= alu_res[63:0];
          state_q <= S_R_N;
        end
        S_R_N: if (alu_done) begin
          sn_q[i_q] <= alu_res[63:0];
          if (i_q == km_q) nm_q <= alu_res[63:0];
          state_q <= S_R_S;
        end
        S_R_S: if (alu_done) begin
          s_q <= s_q + alu_res;
          if (i_q == km_q) begin
            state_q <= S_R_CMP;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= S_R_Q;
          end
        end
        S_R_CMP: begin
          if (g_q == ONE_SQ) begin
            // query lies on the surface
            for (int j = 0; j < 3; j++) sx_q[j] <= 64'(sp_q[j]);
            state_q <= S_OUT;
          end else begin
            lo_q <= nm_q;
            if (g_q < ONE_SQ) begin
              hi_q    <= (em_q < nm_q) ? nm_q : em_q;
              state_q <= S_B_MID;
            end else begin
              state_q <= S_R_SQRT;
            end
          end
        end
        S_R_SQRT: if (alu_done) begin
          hi_q    <= (alu_res[63:0] < lo_q) ? lo_q : alu_res[63:0];
          state_q <= S_B_MID;
        end

        S_B_MID: begin
          i_q <= 2'd0;
          g_q <= '0;
          if (step_q == STEP_LAST) begin
            state_q <= S_R_XM;
          end else begin
            u_q <= mid_w;
            if (mid_w == lo_q || mid_w == hi_q) begin
              state_q <= S_R_XM;
            end else begin
              state_q <= S_B_R;
            end
          end
        end
        S_B_R: if (alu_done) begin
          tq_q    <= rq_w;
          state_q <= S_B_RR;
        end
        S_B_RR: if (alu_done) begin
          g_q <= gsum_w;
          if (i_q == km_q) begin
            state_q <= S_B_CMP;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= S_B_R;
          end
        end
        S_B_CMP: begin
          if (g_q > ONE_SQ) begin
            lo_q    <= u_q;
            step_q  <= step_q + STEP_W'(1);
            state_q <= S_B_MID;
          end else if (g_q < ONE_SQ) begin
            hi_q    <= u_q;
            step_q  <= step_q + STEP_W'(1);
            state_q <= S_B_MID;
          end else begin
            i_q     <= 2'd0;
            state_q <= S_R_XM;
          end
        end
        S_R_XM: if (alu_done) begin
          s_q     <= alu_res;
          state_q <= S_R_XD;
        end
        S_R_XD: if (alu_done) begin
          sx_q[i_q] <= alu_res[63:0];
          if (i_q == km_q) begin
            state_q <= S_OUT;
          end else begin
            i_q     <= i_q + 2'd1;
            state_q <= S_R_XM;
          end
        end
        S_OUT: begin
          // route solver slots back onto the axes they stand for
          unique case (mode_q)
            M_3D: begin
              xv_q[0] <= sx_q[0];
              xv_q[1] <= sx_q[1];
              xv_q[2] <= sx_q[2];
            end
            M_12: begin
              xv_q[1] <= sx_q[0];
              xv_q[2] <= sx_q[1];
            end
            M_02: begin
              xv_q[0] <= sx_q[0];
              xv_q[2] <= sx_q[1];
            end
            default: begin
              xv_q[0] <= sx_q[0];
              xv_q[1] <= sx_q[1];
            end
          endcase
          state_q <= S_F_INIT;
        end

        S_P_E2: if (alu_done) begin
          ta_q    <= alu_res[63:0];
          state_q <= S_P_A0;
        end
        S_P_A0: if (alu_done) begin
          den0_q  <= alu_res[63:0] - ta_q;
          state_q <= S_P_A1;
        end
        S_P_A1: if (alu_done) begin
          den1_q  <= alu_res[63:0] - ta_q;
          state_q <= S_P_N0;
        end
        S_P_N0: if (alu_done) begin
          num0_q  <= alu_res[63:0];
          state_q <= S_P_N1;
        end
        S_P_N1: if (alu_done) begin
          num1_q <= alu_res[63:0];
          if (num0_q < den0_q && alu_res[63:0] < den1_q) begin
            state_q <= S_P_Q0;
          end else begin
            state_q <= S_E_START;
          end
        end
        S_P_Q0: if (alu_done) begin
          q0_q    <= alu_res[63:0];
          state_q <= S_P_Q1;
        end
        S_P_Q1: if (alu_done) begin
          q1_q    <= alu_res[63:0];
          state_q <= S_P_S0;
        end
        S_P_S0: if (alu_done) begin
          g_q     <= alu_res;
          state_q <= S_P_S1;
        end
        S_P_S1: if (alu_done) begin
          g_q <= gsum_w;
          if (gsum_w < ONE_SQ) begin
            state_q <= S_P_X0;
          end else begin
            state_q <= S_E_START;
          end
        end
        S_P_X0: if (alu_done) begin
          xv_q[0] <= 64'(alu_res >> RB);
          state_q <= S_P_X1;
        end
        S_P_X1: if (alu_done) begin
          xv_q[1] <= 64'(alu_res >> RB);
          state_q <= S_P_RT;
        end
        S_P_RT: if (alu_done) begin
          tq_q    <= alu_res[63:0];
          state_q <= S_P_X2;
        end
        S_P_X2: if (alu_done) begin
          xv_q[2] <= 64'(alu_res >> RB);
          state_q <= S_F_INIT;
        end

        S_E_START: begin
          if (pv_q[1] != '0) begin
            if (pv_q[0] != '0) begin
              mode_q  <= M_01;
              km_q    <= 2'd1;
              sa_q[0] <= ax_q[0];
              sa_q[1] <= ax_q[1];
              sp_q[0] <= pv_q[0];
              sp_q[1] <= pv_q[1];
              state_q <= S_R_INIT;
            end else begin
              xv_q[0] <= '0;
              xv_q[1] <= 64'(ax_q[1]);
              state_q <= S_F_INIT;
            end
          end else begin
            state_q <= S_E_D0;
          end
        end
        S_E_D0: if (alu_done) begin
          ta_q    <= alu_res[63:0];
          state_q <= S_E_D1;
        end
        S_E_D1: if (alu_done) begin
          den0_q <= ta_q - alu_res[63:0];
          if (num0_q < ta_q - alu_res[63:0]) begin
            state_q <= S_E_Q;
          end else begin
            xv_q[0] <= 64'(ax_q[0]);
            xv_q[1] <= '0;
            state_q <= S_F_INIT;
          end
        end
        S_E_Q: if (alu_done) begin
          q0_q    <= alu_res[63:0];
          state_q <= S_E_QQ;
        end
        S_E_QQ: if (alu_done) begin
          g_q     <= alu_res;
          state_q <= S_E_RT;
        end
        S_E_RT: if (alu_done) begin
          tq_q    <= alu_res[63:0];
          state_q <= S_E_X0;
        end
        S_E_X0: if (alu_done) begin
          xv_q[0] <= 64'(alu_res >> RB);
          state_q <= S_E_X1;
        end
        S_E_X1: if (alu_done) begin
          xv_q[1] <= 64'(alu_res >> RB);
          state_q <= S_F_INIT;
        end

        S_F_INIT: begin
          s_q     <= '0;
          i_q     <= 2'd0;
          state_q <= S_F_D;
        end
        S_F_D: if (alu_done) begin
          s_q       <= s_q + alu_res;
          xv_q[i_q] <= xc_w;
          if (i_q == 2'd2) begin
            state_q <= S_F_SQ;
          end else begin
            i_q <= i_q + 2'd1;
          end
        end
        S_F_SQ: if (alu_done) begin
          dist_q <= (alu_res[63:32] != '0) ? {COORD_W{1'b1}} : alu_res[31:0];
          for (int j = 0; j < 3; j++) begin
            near_q[j] <= neg_q[j] ? COORD_W'(0) - xv_q[j][31:0] : xv_q[j][31:0];
          end
          state_q <= S_IDLE;
        end

        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/ped_alu.sv]
// Shared multi-cycle multiply, divide and square root unit.
module ped_alu import ped_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  alu_req_t     req_i,
  output logic         done_o,
  output logic [127:0] res_o
);

  logic          busy_q;
  logic [6:0]    cnt_q;
  alu_op_e       op_q;
  logic          sat_q;
  logic [63:0]   a_q, b_q;
  logic [127:0]  acc_q;
  logic [66:0]   rem_q;
  logic [63:0]   root_q;

  logic [6:0]    cm1;
  logic [31:0]   pa, pb;
  logic [63:0]   pp;
  logic [1:0]    sh;
  logic [127:0]  pp_sh;
  logic [63:0]   drem, dnew;
  logic          dge;
  logic [66:0]   srem, strial;
  logic          sge;
  logic          sat_w;

  assign cm1   = cnt_q - 7'd1;
  assign pa    = cm1[1] ? a_q[63:32] : a_q[31:0];
  assign pb    = cm1[0] ? b_q[63:32] : b_q[31:0];
  assign pp    = 64'(pa) * 64'(pb);
  assign sh    = 2'(cm1[1]) + 2'(cm1[0]);
  assign pp_sh = {64'd0, pp} << {sh, 5'd0};

  // restoring divide: carry out of the remainder forces a subtract
  assign drem = {rem_q[62:0], acc_q[63]};
  assign dge  = rem_q[63] || (drem >= b_q);
  assign dnew = dge ? drem - b_q : drem;

  assign srem   = {rem_q[64:0], acc_q[127:126]};
  assign strial = {1'b0, root_q, 2'b01};
  assign sge    = srem >= strial;

  assign sat_w = (req_i.b == 64'd0) || (req_i.x[127:64] >= req_i.b);

  assign done_o = busy_q && (cnt_q == 7'd0);

  always_comb begin
    unique case (op_q)
      OP_MUL:  res_o = acc_q;
      OP_DIV:  res_o = sat_q ? {64'd0, {64{1'b1}}} : {64'd0, acc_q[63:0]};
      OP_SQRT: res_o = {64'd0, root_q};
      default: res_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 7'd0;
    end else if (start_i && !busy_q) begin
      busy_q <= 1'b1;
      if (req_i.op == OP_MUL) begin
        cnt_q <= MUL_STEPS;
      end else if (req_i.op == OP_DIV && sat_w) begin
        cnt_q <= 7'd0;
      end else begin
        cnt_q <= WORD_STEPS;
      end
    end else if (busy_q) begin
      if (cnt_q == 7'd0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cm1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      op_q   <= req_i.op;
      a_q    <= req_i.a;
      b_q    <= req_i.b;
      sat_q  <= sat_w;
      root_q <= 64'd0;
      unique case (req_i.op)
        OP_MUL: begin
          acc_q <= '0;
          rem_q <= '0;
        end
        OP_DIV: begin
          acc_q <= {64'd0, req_i.x[63:0]};
          rem_q <= 67'(req_i.x[127:64]);
        end
        default: begin
          acc_q <= req_i.x;
          rem_q <= '0;
        end
      endcase
    end else if (busy_q && cnt_q != 7'd0) begin
      unique case (op_q)
        OP_MUL: acc_q <= acc_q + pp_sh;
        OP_DIV: begin
          rem_q       <= 67'(dnew);
          acc_q[63:0] <= {acc_q[62:0], dge};
        end
        default: begin
          rem_q  <= sge ? srem - strial : srem;
          acc_q  <= acc_q << 2;
          root_q <= {root_q[62:0], sge};
        end
      endcase
    end
  end

endmodule
